FILE: rtl/nga_pkg.sv
`default_nettype none

package nga_pkg;

  // Number of circuit lines tracked; lines at or above this are ignored
  localparam int LINES = 16;

  localparam int FIELD_W = 16;
  localparam int TGT_W   = 4;

  // Lines that the 16-bit masks can actually carry
  localparam logic [FIELD_W-1:0] LINE_MASK =
      (LINES >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((64'd1 << LINES) - 64'd1);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Input item codes
  localparam logic FUNC_GATE  = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef struct packed {
    logic               func;
    logic [FIELD_W-1:0] ctrl_mask;
    logic [FIELD_W-1:0] polarity_mask;
    logic [TGT_W-1:0]   target_line;
  } gate_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] out_controls;
    logic [FIELD_W-1:0] out_polarity;
    logic [TGT_W-1:0]   out_target;
    logic               last_of_run;
  } result_item_t;

  // Work handed from front to back: a finished gate, or a set of pending lines
  typedef struct packed {
    logic               is_flush;
    logic [FIELD_W-1:0] mask;
    logic [FIELD_W-1:0] polarity;
    logic [TGT_W-1:0]   target;
  } queue_entry_t;

  // Index of the single set bit of a one-hot word
  function automatic logic [TGT_W-1:0] onehot_index(input logic [FIELD_W-1:0] oh);
    logic [TGT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      if (oh[i]) idx = idx | TGT_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/nga_front.sv
`default_nettype none

module nga_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  gate_valid,
  output logic                       gate_stall,
  input  wire nga_pkg::gate_item_t   gate_item,
  input  wire logic                  q_full,
  output logic                       q_push,
  output nga_pkg::queue_entry_t      q_wdata
);
  import nga_pkg::*;

  logic [FIELD_W-1:0] pending_not;
  logic [FIELD_W-1:0] pending_not_next;
  logic [FIELD_W-1:0] pend;
  logic [FIELD_W-1:0] ctl;
  logic [FIELD_W-1:0] pol;
  logic [FIELD_W-1:0] tb;
  logic               accept;
  logic               single_ctl;

  assign gate_stall = q_full;
  assign accept     = gate_valid && !q_full;

  assign pend = pending_not & LINE_MASK;
  assign ctl  = gate_item.ctrl_mask & LINE_MASK;
  assign pol  = gate_item.polarity_mask;
  // Target bit; a target beyond the tracked lines has none
  assign tb   = (FIELD_W'(1) << gate_item.target_line) & LINE_MASK;
  assign single_ctl = (ctl != '0) && ((ctl & (ctl - FIELD_W'(1))) == '0);

  // Classify the item, fold pending NOTs into it, work out the new state
  always_comb begin
    pending_not_next = pending_not;
    q_push           = 1'b0;
    q_wdata          = '0;
    q_wdata.target   = gate_item.target_line;
    if (accept) begin
      if (gate_item.func == FUNC_FLUSH) begin
        q_wdata.is_flush = 1'b1;
        q_wdata.mask     = pend;
        q_push           = (pend != '0);
        pending_not_next = '0;
      end else if (ctl == '0) begin
        // NOT gate: absorbed into the pending state
        pending_not_next = (pending_not ^ tb) & LINE_MASK;
      end else if (single_ctl && ((pend & tb) != '0)) begin
        // Single control absorbs the target's pending NOT
        q_wdata.mask     = ctl;
        q_wdata.polarity = (~pol ^ pend) & ctl;
        q_push           = 1'b1;
        pending_not_next = pend & ~tb;
      end else begin
        q_wdata.mask     = ctl;
        q_wdata.polarity = (pol ^ pend) & ctl;
        q_push           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_not <= '0;
    end else begin
      pending_not <= pending_not_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nga_queue.sv
`default_nettype none

module nga_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire nga_pkg::queue_entry_t  wdata,
  input  wire logic                   pop,
  output nga_pkg::queue_entry_t       rdata,
  output logic                        full,
  output logic                        empty
);
  import nga_pkg::*;

  queue_entry_t          mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + QUEUE_AW'(1);
      case ({push, pop})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nga_back.sv
`default_nettype none

module nga_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire nga_pkg::queue_entry_t  q_rdata,
  input  wire logic                   q_empty,
  output logic                        q_pop,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output nga_pkg::result_item_t       result_item
);
  import nga_pkg::*;

  logic [FIELD_W-1:0] remain;
  logic [FIELD_W-1:0] remain_next;
  logic [FIELD_W-1:0] src_mask;
  logic [FIELD_W-1:0] low_bit;
  logic               take;
  logic               busy;

  // Output register free, or its result being transferred
  assign take  = !result_valid || !result_stall;
  assign busy  = (remain != '0);
  assign q_pop = take && !busy && !q_empty;

  // Next pending line of the flush in progress or of a fresh flush entry
  assign src_mask    = busy ? remain : q_rdata.mask;
  assign low_bit     = src_mask & (~src_mask + FIELD_W'(1));
  assign remain_next = src_mask & ~low_bit;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      remain       <= '0;
    end else if (take) begin
      if (busy) begin
        result_valid <= 1'b1;
        remain       <= remain_next;
      end else if (!q_empty) begin
        result_valid <= 1'b1;
        remain       <= q_rdata.is_flush ? remain_next : '0;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      if (busy || q_rdata.is_flush) begin
        result_item.out_controls <= '0;
        result_item.out_polarity <= '0;
        result_item.out_target   <= onehot_index(low_bit);
        result_item.last_of_run  <= (remain_next == '0);
      end else begin
        result_item.out_controls <= q_rdata.mask;
        result_item.out_polarity <= q_rdata.polarity;
        result_item.out_target   <= q_rdata.target;
        result_item.last_of_run  <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/not_gate_absorber_unit.sv
// A gate's result passes through the queue and is registered at the output. One gate per cycle
// is taken while the queue is not full; a NOT gate is absorbed and gives no result.
// A flush gives one NOT gate per pending line, one per cycle while the output is not stalled, as
// the back end walks the pending mask lowest line first; the front keeps taking items while the
// queue is not full. Reset (synchronous, active high) clears the pending NOTs, queue and output.
`default_nettype none

module not_gate_absorber_unit (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   gate_valid,
  output logic                        gate_stall,
  input  wire nga_pkg::gate_item_t    gate_item,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output nga_pkg::result_item_t       result_item
);
  import nga_pkg::*;

  logic         q_push;
  logic         q_pop;
  logic         q_full;
  logic         q_empty;
  queue_entry_t q_wdata;
  queue_entry_t q_rdata;

  // Classification and pending state
  nga_front u_front (
    .clk        (clk),
    .rst        (rst),
    .gate_valid (gate_valid),
    .gate_stall (gate_stall),
    .gate_item  (gate_item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  // Decoupling queue
  nga_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Result generation
  nga_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_rdata      (q_rdata),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import nga_pkg::*;

  localparam int RUN_LIMIT   = 200000;
  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_WAIT  = 20;

  logic         clk;
  logic         rst;
  logic         gate_valid;
  logic         gate_stall;
  gate_item_t   gate_item;
  logic         result_valid;
  logic         result_stall;
  result_item_t result_item;

  not_gate_absorber_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .gate_valid   (gate_valid),
    .gate_stall   (gate_stall),
    .gate_item    (gate_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  // Predicted pending NOTs and the gates still due out of the block
  logic [FIELD_W-1:0] pend_nots;
  result_item_t       expected_gates[$];

  int errors    = 0;
  int n_items   = 0;
  int n_nots    = 0;
  int n_flushes = 0;
  int n_results = 0;
  int cycles    = 0;
  int burst_left;
  bit steady;
  bit hold_req;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Fold one accepted item into the predicted state and queue its gates
  function automatic void absorb_gate(input gate_item_t g);
    logic [FIELD_W-1:0] ctl;
    logic [FIELD_W-1:0] tbit;
    logic [FIELD_W-1:0] rest;
    result_item_t       r;
    if (g.func == FUNC_FLUSH) begin
      n_flushes++;
      rest = pend_nots & LINE_MASK;
      for (int ln = 0; ln < FIELD_W; ln++) begin
        if (rest[ln]) begin
          rest[ln]       = 1'b0;
          r.out_controls = '0;
          r.out_polarity = '0;
          r.out_target   = TGT_W'(ln);
          r.last_of_run  = (rest == '0);
          expected_gates = {expected_gates, r};
        end
      end
      pend_nots = '0;
    end else begin
      ctl  = g.ctrl_mask & LINE_MASK;
      tbit = (FIELD_W'(1) << g.target_line) & LINE_MASK;
      r.out_controls = ctl;
      r.out_target   = g.target_line;
      r.last_of_run  = 1'b1;
      if (ctl == '0) begin
        // bare NOT: absorbed, nothing out
        n_nots++;
        pend_nots = (pend_nots ^ tbit) & LINE_MASK;
      end else if ($countones(ctl) == 1 && (pend_nots & tbit) != '0) begin
        // single control soaks up the target's pending NOT
        r.out_polarity = (~g.polarity_mask ^ pend_nots) & ctl;
        expected_gates = {expected_gates, r};
        pend_nots = pend_nots & ~tbit;
      end else begin
        r.out_polarity = (g.polarity_mask ^ pend_nots) & ctl;
        expected_gates = {expected_gates, r};
      end
    end
  endfunction

  function automatic gate_item_t mk_gate(input logic f, input logic [FIELD_W-1:0] ctl,
                                         input logic [FIELD_W-1:0] pol,
                                         input logic [TGT_W-1:0] tgt);
    gate_item_t g;
    g.func          = f;
    g.ctrl_mask     = ctl;
    g.polarity_mask = pol;
    g.target_line   = tgt;
    return g;
  endfunction

  // Random item, weighted towards NOTs and single controls that hit pending lines
  function automatic gate_item_t rand_gate();
    gate_item_t g;
    int         kind;
    g    = mk_gate(FUNC_GATE, FIELD_W'($urandom), FIELD_W'($urandom),
                   TGT_W'($urandom_range(0, 15)));
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      g.ctrl_mask = '0;
    end else if (kind < 58) begin
      g.ctrl_mask = FIELD_W'(1) << $urandom_range(0, 15);
      if (pend_nots != '0 && $urandom_range(0, 4) != 0) begin
        do g.target_line = TGT_W'($urandom_range(0, 15));
        while (!pend_nots[g.target_line]);
      end
    end else if (kind < 66) begin
      g.func = FUNC_FLUSH;
    end else if (kind < 90) begin
      g.ctrl_mask = FIELD_W'($urandom) & FIELD_W'($urandom);
    end
    return g;
  endfunction

  // Offer one item, with burst/gap pacing unless running steady
  task automatic push_gate(input gate_item_t g);
    int gap;
    if (!steady && burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        gate_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    gate_valid <= 1'b1;
    gate_item  <= g;
    @(posedge clk);
    while (gate_stall) @(posedge clk);
    absorb_gate(g);
    n_items++;
  endtask

  // Receiver: changing stall pattern, plus a long hold on request
  initial begin
    int mode;
    int left;
    result_stall = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 60);
      end
      left--;
      case (mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 9) < 3);
        2: result_stall <= (left % 3 == 0);
        default: result_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  function automatic void check_field(input string name, input logic [FIELD_W-1:0] want,
                                      input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %h, got %h", name, want, got);
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    result_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_gates.size() == 0) begin
        errors++;
        $error("unexpected result transfer %h", result_item);
      end else begin
        want = expected_gates.pop_front();
        n_results++;
        check_field("out_controls", want.out_controls, result_item.out_controls);
        check_field("out_polarity", want.out_polarity, result_item.out_polarity);
        check_field("out_target", FIELD_W'(want.out_target), FIELD_W'(result_item.out_target));
        check_field("last_of_run", FIELD_W'(want.last_of_run),
                    FIELD_W'(result_item.last_of_run));
      end
    end
  end

  // Hand-picked gates: absorption, folding, target among controls, flushes
  task automatic test_gate_rules();
    push_gate(mk_gate(FUNC_GATE, 16'h0000, 16'hFFFF, 4'd0));
    push_gate(mk_gate(FUNC_GATE, 16'h0000, 16'h0000, 4'd15));
    // every line a control, both pending lines fold into polarity
    push_gate(mk_gate(FUNC_GATE, 16'hFFFF, 16'hFFFF, 4'd15));
    // single control onto pending line 0, control line itself pending
    push_gate(mk_gate(FUNC_GATE, 16'h8000, 16'h0000, 4'd0));
    // single control on its own pending target
    push_gate(mk_gate(FUNC_GATE, 16'h0000, 16'h0000, 4'd7));
    push_gate(mk_gate(FUNC_GATE, 16'h0080, 16'h0080, 4'd7));
    // single control, target not pending
    push_gate(mk_gate(FUNC_GATE, 16'h0008, 16'h0000, 4'd9));
    // NOT twice cancels
    push_gate(mk_gate(FUNC_GATE, 16'h0000, 16'h1234, 4'd2));
    push_gate(mk_gate(FUNC_GATE, 16'h0000, 16'h4321, 4'd2));
    // flush ignores its other fields; second flush has nothing left
    push_gate(mk_gate(FUNC_FLUSH, 16'hFFFF, 16'hFFFF, 4'd15));
    push_gate(mk_gate(FUNC_FLUSH, 16'h0000, 16'h0000, 4'd0));
  endtask

  // Every line pending, then one flush: the longest run of results
  task automatic test_full_flush();
    for (int ln = 0; ln < FIELD_W; ln++)
      push_gate(mk_gate(FUNC_GATE, '0, FIELD_W'($urandom), TGT_W'(ln)));
    push_gate(mk_gate(FUNC_FLUSH, FIELD_W'($urandom), FIELD_W'($urandom),
                      TGT_W'($urandom)));
  endtask

  // Random stream with a stretch of back-to-back transfers in the middle
  task automatic test_random_stream(input int count);
    for (int i = 0; i < count; i++) begin
      steady = (i >= count / 3 && i < count / 2);
      push_gate(rand_gate());
    end
    steady = 1'b0;
  endtask

  // Long receiver hold while the sender keeps going, so the block backs up
  task automatic test_backpressure(input int count);
    gate_item_t g;
    hold_req = 1'b1;
    steady   = 1'b1;
    for (int i = 0; i < count; i++) begin
      g = rand_gate();
      if (g.func == FUNC_FLUSH || g.ctrl_mask == '0) begin
        g.func      = FUNC_GATE;
        g.ctrl_mask = g.ctrl_mask | (FIELD_W'(1) << $urandom_range(0, 15));
      end
      push_gate(g);
    end
    steady = 1'b0;
  endtask

  // Sequence
  initial begin
    rst        = 1'b1;
    gate_valid = 1'b0;
    gate_item  = '0;
    pend_nots  = '0;
    burst_left = 0;
    steady     = 1'b0;
    hold_req   = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_gate_rules();
    test_full_flush();
    test_random_stream(60);
    test_backpressure(30);
    push_gate(mk_gate(FUNC_FLUSH, '0, '0, '0));

    gate_valid <= 1'b0;
    while (expected_gates.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d items: %0d NOT gates absorbed, %0d flushes.",
             n_items, n_nots, n_flushes);
    $display("Checked %0d emitted gates under bursty input and output stalls, %0d errors.",
             n_results, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/nga_pkg.sv
rtl/nga_front.sv
rtl/nga_queue.sv
rtl/nga_back.sv
rtl/not_gate_absorber_unit.sv
verif/tb.sv
